// ===== design/tsgs_pkg.sv =====
package tsgs_pkg;

    // field widths
    localparam int W_RATE   = 32;
    localparam int W_TIME   = 48;
    localparam int W_SUM    = W_RATE + 1;
    localparam int W_NLN    = 38;
    localparam int W_DCNT   = 6;
    localparam int W_ADDR   = 6;
    localparam int W_APB    = 64;
    localparam int W_IN     = 64;
    localparam int W_OUT    = 56;
    localparam int LOG_ROUNDS = 32;

    // ln 2 as an unsigned Q0.32 fraction
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    // register reset values
    localparam logic [W_RATE-1:0] RATE_RESET = 32'd65536;
    localparam logic [W_TIME-1:0] END_RESET  = 48'd6553600;

    // register indexes, byte address is 8 times the index
    localparam logic [2:0] REG_RATE_A_TO_B = 3'd0;
    localparam logic [2:0] REG_RATE_B_TO_A = 3'd1;
    localparam logic [2:0] REG_RATE_B_TO_C = 3'd2;
    localparam logic [2:0] REG_RATE_C_TO_A = 3'd3;
    localparam logic [2:0] REG_END_TIME    = 3'd4;

    // species codes
    localparam logic [1:0] SP_A = 2'd0;
    localparam logic [1:0] SP_B = 2'd1;
    localparam logic [1:0] SP_C = 2'd2;

    // reaction codes
    localparam logic [1:0] RX_A_TO_B = 2'd0;
    localparam logic [1:0] RX_B_TO_A = 2'd1;
    localparam logic [1:0] RX_B_TO_C = 2'd2;
    localparam logic [1:0] RX_C_TO_A = 2'd3;

    // run status codes
    localparam logic [2:0] STS_START   = 3'd0;
    localparam logic [2:0] STS_EVENT   = 3'd1;
    localparam logic [2:0] STS_FINAL   = 3'd2;
    localparam logic [2:0] STS_HALTED  = 3'd3;
    localparam logic [2:0] STS_IGNORED = 3'd4;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SEL1,
        S_SEL2,
        S_LOG,
        S_LSUB,
        S_LNLO,
        S_LNHI,
        S_DSTART,
        S_DIV,
        S_TIME,
        S_FINISH
    } t_state;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== design/three_state_gillespie_step_core.sv =====
// Direct-method stochastic step for one molecule switching among states A, B, C.
// Input stream: s_axis_tuser is the command (0 advance, 1 restart in A at time 0),
// s_axis_tdata carries the waiting-time draw and the reaction-choice draw.
// Output stream: one transfer per input transfer, holding the one-hot state after
// the item, the reaction fired, the Q32.16 clock and the run status in tuser.
// The user must write rates and the end time through the APB port only while the block is
// idle; the block itself does not enforce this. An advance is built from 32 squaring rounds
// of the logarithm on the shared 33x32 multiplier, two multiplier passes for ln 2 scaling,
// two more for the choice out of state B, and a 38-step restoring divider for the waiting
// time. Restart, ignored and halted items go straight to the result.
// One item is in work at a time; s_axis_tready is high only when the sequencer is idle,
// so the next item is taken only after a result is registered.
// The result sits in an output register, so the next item is taken while it waits;
// a stalled receiver holds that item at its last step until the register frees.
// Synchronous reset puts the run in state A at time zero, open, with rates of 1.0
// and an end time of 100.0, and drops m_axis_tvalid.
module three_state_gillespie_step_core
    import tsgs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // stream in
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [W_IN-1:0]   s_axis_tdata,   // wait_random[31:0], select_random[63:32]
    input  logic [0:0]        s_axis_tuser,   // cmd[0]
    // stream out
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [W_OUT-1:0]  m_axis_tdata,   // species_a[0], species_b[1], species_c[2],
                                              // reaction_taken[4:3], event_time[52:5], zero
    output logic [2:0]        m_axis_tuser,   // run_status[2:0]
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [W_ADDR-1:0] paddr,
    input  logic [W_APB-1:0]  pwdata,
    output logic [W_APB-1:0]  prdata,
    output logic              pready
);

    // configuration registers
    logic [W_RATE-1:0] r_k1, r_k2, r_k3, r_k4;
    logic [W_TIME-1:0] r_end;

    // run state
    logic [1:0]        r_species, n_species;
    logic [W_TIME-1:0] r_time, n_time;
    logic              r_over, n_over;

    // sequencer
    t_state            r_state, n_state;
    logic [4:0]        r_cnt, n_cnt;

    // item registers
    logic              r_cmd, n_cmd;
    logic [31:0]       r_wait, n_wait;
    logic [31:0]       r_sel, n_sel;
    logic [W_SUM-1:0]  r_sum, n_sum;
    logic [4:0]        r_e, n_e;
    logic [31:0]       r_m, n_m;
    logic [31:0]       r_frac, n_frac;
    logic [64:0]       r_prod, n_prod;
    logic [31:0]       r_lnlo, n_lnlo;
    logic [W_NLN-1:0]  r_num, n_num;

    // pending result
    logic [1:0]        r_nxt_spec, n_nxt_spec;
    logic [W_TIME-1:0] r_nxt_time, n_nxt_time;
    logic              r_nxt_over, n_nxt_over;
    logic [1:0]        r_nxt_react, n_nxt_react;
    logic [2:0]        r_nxt_sts, n_nxt_sts;

    // output register
    logic              r_out_valid, n_out_valid;
    logic [W_OUT-1:0]  r_out_data, n_out_data;
    logic [2:0]        r_out_user, n_out_user;

    // shared multiplier
    logic [W_SUM-1:0]  mul_a;
    logic [31:0]       mul_b;
    logic [64:0]       mul_p;

    // helpers
    logic [31:0]       norm_w;
    logic [4:0]        norm_e;
    logic [31:0]       norm_m;
    logic [W_SUM-1:0]  sum_rates;
    logic [W_TIME:0]   t_sum;
    logic              div_start;
    t_div_stat         div_stat;
    logic [W_NLN-1:0]  div_quo;
    logic              cfg_wr;
    logic              sp_a, sp_b;

    assign mul_p = mul_a * mul_b;

    // waiting-time divider
    tsgs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_den   (r_sum),
        .o_stat  (div_stat),
        .o_quo   (div_quo)
    );

    // apb access
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb begin
        unique case (paddr[5:3])
            REG_RATE_A_TO_B: prdata = {32'd0, r_k1};
            REG_RATE_B_TO_A: prdata = {32'd0, r_k2};
            REG_RATE_B_TO_C: prdata = {32'd0, r_k3};
            REG_RATE_C_TO_A: prdata = {32'd0, r_k4};
            REG_END_TIME:    prdata = {16'd0, r_end};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k1  <= RATE_RESET;
            r_k2  <= RATE_RESET;
            r_k3  <= RATE_RESET;
            r_k4  <= RATE_RESET;
            r_end <= END_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[5:3])
                REG_RATE_A_TO_B: r_k1  <= pwdata[W_RATE-1:0];
                REG_RATE_B_TO_A: r_k2  <= pwdata[W_RATE-1:0];
                REG_RATE_B_TO_C: r_k3  <= pwdata[W_RATE-1:0];
                REG_RATE_C_TO_A: r_k4  <= pwdata[W_RATE-1:0];
                REG_END_TIME:    r_end <= pwdata[W_TIME-1:0];
                default: ;
            endcase
        end
    end

    // msb search and normalization of the waiting draw, zero taken as one
    always_comb begin
        norm_w = (r_wait == 32'd0) ? 32'd1 : r_wait;
        norm_e = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (norm_w[i]) norm_e = 5'(i);
        end
        norm_m = norm_w << (5'd31 - norm_e);
    end

    // total propensity of the current state
    always_comb begin
        case (r_species)
            SP_A:    sum_rates = {1'b0, r_k1};
            SP_B:    sum_rates = {1'b0, r_k2} + {1'b0, r_k3};
            default: sum_rates = {1'b0, r_k4};
        endcase
    end

    // clock after this event, one bit wider to see overflow
    assign t_sum = {1'b0, r_time} + (W_TIME+1)'(div_quo);

    // one-hot state of the pending result
    assign sp_a = (r_nxt_spec == SP_A);
    assign sp_b = (r_nxt_spec == SP_B);

    assign s_axis_tready = (r_state == S_IDLE);
    assign div_start     = (r_state == S_DSTART);

    // next state and datapath
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_cmd       = r_cmd;
        n_wait      = r_wait;
        n_sel       = r_sel;
        n_sum       = r_sum;
        n_e         = r_e;
        n_m         = r_m;
        n_frac      = r_frac;
        n_prod      = r_prod;
        n_lnlo      = r_lnlo;
        n_num       = r_num;
        n_nxt_spec  = r_nxt_spec;
        n_nxt_time  = r_nxt_time;
        n_nxt_over  = r_nxt_over;
        n_nxt_react = r_nxt_react;
        n_nxt_sts   = r_nxt_sts;
        n_species   = r_species;
        n_time      = r_time;
        n_over      = r_over;
        n_out_valid = r_out_valid & ~m_axis_tready;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        mul_a       = '0;
        mul_b       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cmd   = s_axis_tuser[0];
                    n_wait  = s_axis_tdata[31:0];
                    n_sel   = s_axis_tdata[63:32];
                    n_state = S_CHECK;
                end
            end

            // early outcomes and setup for an event
            S_CHECK: begin
                n_nxt_spec  = r_species;
                n_nxt_time  = r_time;
                n_nxt_over  = 1'b1;
                n_nxt_react = RX_A_TO_B;
                n_sum       = sum_rates;
                n_e         = norm_e;
                n_m         = norm_m;
                n_cnt       = '0;
                if (r_cmd) begin
                    n_nxt_spec = SP_A;
                    n_nxt_time = '0;
                    n_nxt_over = 1'b0;
                    n_nxt_sts  = STS_START;
                    n_state    = S_FINISH;
                end else if (r_over || (r_time >= r_end)) begin
                    n_nxt_sts = STS_IGNORED;
                    n_state   = S_FINISH;
                end else if (sum_rates == '0) begin
                    n_nxt_sts = STS_HALTED;
                    n_state   = S_FINISH;
                end else begin
                    case (r_species)
                        SP_A: begin
                            n_nxt_react = RX_A_TO_B;
                            n_nxt_spec  = SP_B;
                            n_state     = S_LOG;
                        end
                        SP_B: begin
                            n_state = S_SEL1;
                        end
                        default: begin
                            n_nxt_react = RX_C_TO_A;
                            n_nxt_spec  = SP_A;
                            n_state     = S_LOG;
                        end
                    endcase
                end
            end

            // k2 * (2^32 - select)
            S_SEL1: begin
                mul_a   = 33'h1_0000_0000 - {1'b0, r_sel};
                mul_b   = r_k2;
                n_prod  = mul_p;
                n_state = S_SEL2;
            end

            // select * k3 against the stored product
            S_SEL2: begin
                mul_a = {1'b0, r_sel};
                mul_b = r_k3;
                if (mul_p < r_prod) begin
                    n_nxt_react = RX_B_TO_A;
                    n_nxt_spec  = SP_A;
                end else begin
                    n_nxt_react = RX_B_TO_C;
                    n_nxt_spec  = SP_C;
                end
                n_state = S_LOG;
            end

            // one fraction bit of log2 per squaring of the mantissa
            S_LOG: begin
                mul_a  = {1'b0, r_m};
                mul_b  = r_m;
                n_frac = {r_frac[30:0], mul_p[63]};
                n_m    = mul_p[63] ? mul_p[63:32] : mul_p[62:31];
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == 5'(LOG_ROUNDS - 1)) begin
                    n_state = S_LSUB;
                end
            end

            // 32 minus log2 of the draw, Q.32
            S_LSUB: begin
                n_num   = {6'd32, 32'd0} - {1'b0, r_e, r_frac};
                n_state = S_LNLO;
            end

            // fraction part times ln 2
            S_LNLO: begin
                mul_a   = {1'b0, r_num[31:0]};
                mul_b   = LN2_Q32;
                n_lnlo  = mul_p[63:32];
                n_state = S_LNHI;
            end

            // integer part times ln 2, plus the fraction part
            S_LNHI: begin
                mul_a   = {27'd0, r_num[37:32]};
                mul_b   = LN2_Q32;
                n_num   = mul_p[W_NLN-1:0] + {6'd0, r_lnlo};
                n_state = S_DSTART;
            end

            S_DSTART: begin
                n_state = S_DIV;
            end

            S_DIV: begin
                if (div_stat.done) begin
                    n_state = S_TIME;
                end
            end

            // advance the clock, saturate and close the run where due
            S_TIME: begin
                if (t_sum[W_TIME]) begin
                    n_nxt_time = '1;
                    n_nxt_over = 1'b1;
                    n_nxt_sts  = STS_FINAL;
                end else if (t_sum[W_TIME-1:0] >= r_end) begin
                    n_nxt_time = t_sum[W_TIME-1:0];
                    n_nxt_over = 1'b1;
                    n_nxt_sts  = STS_FINAL;
                end else begin
                    n_nxt_time = t_sum[W_TIME-1:0];
                    n_nxt_over = 1'b0;
                    n_nxt_sts  = STS_EVENT;
                end
                n_state = S_FINISH;
            end

            // commit the run state and hand the result to the output register
            S_FINISH: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_species   = r_nxt_spec;
                    n_time      = r_nxt_time;
                    n_over      = r_nxt_over;
                    n_out_valid = 1'b1;
                    n_out_data  = {3'd0, r_nxt_time, r_nxt_react,
                                   ~(sp_a | sp_b), sp_b, sp_a};
                    n_out_user  = r_nxt_sts;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_species   <= SP_A;
            r_time      <= '0;
            r_over      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_species   <= n_species;
            r_time      <= n_time;
            r_over      <= n_over;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_cnt       <= n_cnt;
        r_cmd       <= n_cmd;
        r_wait      <= n_wait;
        r_sel       <= n_sel;
        r_sum       <= n_sum;
        r_e         <= n_e;
        r_m         <= n_m;
        r_frac      <= n_frac;
        r_prod      <= n_prod;
        r_lnlo      <= n_lnlo;
        r_num       <= n_num;
        r_nxt_spec  <= n_nxt_spec;
        r_nxt_time  <= n_nxt_time;
        r_nxt_over  <= n_nxt_over;
        r_nxt_react <= n_nxt_react;
        r_nxt_sts   <= n_nxt_sts;
        r_out_data  <= n_out_data;
        r_out_user  <= n_out_user;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

// ===== design/tsgs_div.sv =====
module tsgs_div
    import tsgs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [W_NLN-1:0] i_num,
    input  logic [W_SUM-1:0] i_den,
    output t_div_stat        o_stat,
    output logic [W_NLN-1:0] o_quo
);

    logic              r_busy;
    logic              r_done;
    logic [W_DCNT-1:0] r_cnt;
    logic [W_NLN-1:0]  r_quo;
    logic [W_SUM-1:0]  r_rem;

    logic [W_SUM:0]    shifted;
    logic [W_SUM:0]    diff;
    logic              ge;

    // one restoring step: shift in the next dividend bit, try the subtract
    always_comb begin
        shifted = {r_rem, r_quo[W_NLN-1]};
        ge      = (shifted >= {1'b0, i_den});
        diff    = shifted - {1'b0, i_den};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == W_DCNT'(W_NLN - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift in where dividend bits leave
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[W_NLN-2:0], ge};
            r_rem <= ge ? diff[W_SUM-1:0] : shifted[W_SUM-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;

endmodule

// ===== sim/gillespie_step_checker.sv =====
`timescale 1ns / 100ps

module gillespie_step_checker
    import tsgs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input stream as seen on the wires
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [W_IN-1:0]   i_in_data,     // wait_random[31:0], select_random[63:32]
    input  logic [0:0]        i_in_cmd,      // cmd[0]
    // output stream as seen on the wires
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [W_OUT-1:0]  i_out_data,    // species_a[0], species_b[1], species_c[2],
                                             // reaction_taken[4:3], event_time[52:5]
    input  logic [2:0]        i_out_status,  // run_status[2:0]
    // register port
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [W_ADDR-1:0] i_paddr,
    input  logic [W_APB-1:0]  i_pwdata,
    // status toward the stimulus side
    output int                o_mismatches,
    output int                o_pending,
    output int                o_live_results,
    output logic              o_run_closed
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic              in_a;
        logic              in_b;
        logic              in_c;
        logic [1:0]        reaction;
        logic [W_TIME-1:0] ev_time;
        logic [2:0]        status;
    } t_step_record;

    // own copy of the rate registers and the molecule
    logic [W_RATE-1:0] k_ab, k_ba, k_bc, k_ca;
    logic [W_TIME-1:0] stop_time;
    logic [1:0]        species;
    logic [W_TIME-1:0] clock_q;
    logic              run_closed;

    t_step_record      expected_records[$];
    t_step_record      want, seen;
    int                mismatch_total;
    int                live_total;

    // log2 of a 32-bit value: msb index above 32 fraction bits by repeated squaring
    function automatic logic [63:0] log2_fixed(input logic [31:0] w);
        logic [31:0] msb;
        logic [63:0] mant, sq;
        logic [31:0] frac;
        int          round;
        msb = 32'd31;
        while (msb > 0 && w[msb] == 1'b0) msb--;
        mant = {32'd0, w} << (32'd31 - msb);
        frac = '0;
        for (round = 0; round < LOG_ROUNDS; round++) begin
            sq = mant * mant;
            frac = {frac[30:0], sq[63]};
            mant = sq[63] ? (sq >> 32) : (sq >> 31);
        end
        return {msb, frac};
    endfunction

    // -ln(w / 2^32) in Q.32, a zero draw counts as one
    function automatic logic [63:0] neg_ln_fixed(input logic [31:0] w);
        logic [63:0] l, hi_part, lo_part;
        if (w == '0) w = 32'd1;
        l = {32'd32, 32'd0} - log2_fixed(w);
        hi_part = {32'd0, l[63:32]} * {32'd0, LN2_Q32};
        lo_part = ({32'd0, l[31:0]} * {32'd0, LN2_Q32}) >> 32;
        return hi_part + lo_part;
    endfunction

    // one step of the molecule, updates the local state and returns the record
    function automatic t_step_record advance_molecule(input logic cmd, input logic [31:0] w,
                                                      input logic [31:0] s);
        t_step_record rec;
        logic [32:0]  total;
        logic [63:0]  tau, t_next;
        logic [65:0]  sel_w, lhs, rhs;
        rec.reaction = RX_A_TO_B;
        if (cmd) begin
            species = SP_A;
            clock_q = '0;
            run_closed = 1'b0;
            rec.status = STS_START;
        end else if (run_closed) begin
            rec.status = STS_IGNORED;
        end else if (clock_q >= stop_time) begin
            run_closed = 1'b1;
            rec.status = STS_IGNORED;
        end else begin
            case (species)
                SP_A: total = {1'b0, k_ab};
                SP_B: total = {1'b0, k_ba} + {1'b0, k_bc};
                default: total = {1'b0, k_ca};
            endcase
            if (total == '0) begin
                run_closed = 1'b1;
                rec.status = STS_HALTED;
            end else begin
                tau = neg_ln_fixed(w) / total;
                // pick the reaction out of the current state
                case (species)
                    SP_A: begin
                        rec.reaction = RX_A_TO_B;
                        species = SP_B;
                    end
                    SP_B: begin
                        sel_w = {34'd0, s};
                        lhs = sel_w * {34'd0, k_bc};
                        rhs = {34'd0, k_ba} * ((66'd1 << 32) - sel_w);
                        if (lhs < rhs) begin
                            rec.reaction = RX_B_TO_A;
                            species = SP_A;
                        end else begin
                            rec.reaction = RX_B_TO_C;
                            species = SP_C;
                        end
                    end
                    default: begin
                        rec.reaction = RX_C_TO_A;
                        species = SP_A;
                    end
                endcase
                // saturating clock, the event reaching the stop time closes the run
                t_next = {16'd0, clock_q} + tau;
                if (t_next > {16'd0, {W_TIME{1'b1}}}) begin
                    clock_q = '1;
                    run_closed = 1'b1;
                    rec.status = STS_FINAL;
                end else begin
                    clock_q = t_next[W_TIME-1:0];
                    if (clock_q >= stop_time) begin
                        run_closed = 1'b1;
                        rec.status = STS_FINAL;
                    end else begin
                        rec.status = STS_EVENT;
                    end
                end
            end
        end
        rec.in_a = (species == SP_A);
        rec.in_b = (species == SP_B);
        rec.in_c = (species >= SP_C);
        rec.ev_time = clock_q;
        return rec;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            k_ab = RATE_RESET;
            k_ba = RATE_RESET;
            k_bc = RATE_RESET;
            k_ca = RATE_RESET;
            stop_time = END_RESET;
            species = SP_A;
            clock_q = '0;
            run_closed = 1'b0;
            expected_records.delete();
            mismatch_total = 0;
            live_total = 0;
            o_mismatches <= 0;
            o_pending <= 0;
            o_live_results <= 0;
            o_run_closed <= 1'b0;
        end else begin
            // register writes
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[W_ADDR-1:3])
                    REG_RATE_A_TO_B: k_ab = i_pwdata[W_RATE-1:0];
                    REG_RATE_B_TO_A: k_ba = i_pwdata[W_RATE-1:0];
                    REG_RATE_B_TO_C: k_bc = i_pwdata[W_RATE-1:0];
                    REG_RATE_C_TO_A: k_ca = i_pwdata[W_RATE-1:0];
                    REG_END_TIME:    stop_time = i_pwdata[W_TIME-1:0];
                    default: ;
                endcase
            end

            // predict on every input transfer
            if (i_in_valid && i_in_ready) begin
                want = advance_molecule(i_in_cmd[0], i_in_data[31:0], i_in_data[63:32]);
                expected_records.push_back(want);
                if (want.status != STS_IGNORED) live_total = live_total + 1;
            end

            // compare every output transfer with the oldest expectation
            if (i_out_valid && i_out_ready) begin
                seen.in_a = i_out_data[0];
                seen.in_b = i_out_data[1];
                seen.in_c = i_out_data[2];
                seen.reaction = i_out_data[4:3];
                seen.ev_time = i_out_data[5 +: W_TIME];
                seen.status = i_out_status;
                if (expected_records.size() == 0) begin
                    mismatch_total = mismatch_total + 1;
                    if (mismatch_total <= REPORT_LIMIT)
                        $display("%0t: unexpected result a%0b b%0b c%0b rx %0d t %h st %0d",
                                 $time, seen.in_a, seen.in_b, seen.in_c, seen.reaction,
                                 seen.ev_time, seen.status);
                end else begin
                    want = expected_records.pop_front();
                    if (seen.in_a !== want.in_a || seen.in_b !== want.in_b
                            || seen.in_c !== want.in_c || seen.reaction !== want.reaction
                            || seen.ev_time !== want.ev_time || seen.status !== want.status)
                    begin
                        mismatch_total = mismatch_total + 1;
                        if (mismatch_total <= REPORT_LIMIT) begin
                            $display("%0t: result mismatch", $time);
                            $display("  expected a%0b b%0b c%0b rx %0d t %h st %0d",
                                     want.in_a, want.in_b, want.in_c, want.reaction,
                                     want.ev_time, want.status);
                            $display("  actual   a%0b b%0b c%0b rx %0d t %h st %0d",
                                     seen.in_a, seen.in_b, seen.in_c, seen.reaction,
                                     seen.ev_time, seen.status);
                        end
                    end
                end
            end

            o_mismatches <= mismatch_total;
            o_pending <= expected_records.size();
            o_live_results <= live_total;
            o_run_closed <= run_closed;
        end
    end

endmodule

// ===== sim/three_state_gillespie_step_core_tb.sv =====
`timescale 1ns / 100ps

module three_state_gillespie_step_core_tb
    import tsgs_pkg::*;
();

    localparam int IDLE_LIMIT     = 4000;
    localparam int LIVE_PER_PHASE = 250;
    localparam int RANDOM_PHASES  = 6;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [W_IN-1:0]   s_axis_tdata = '0;   // wait_random[31:0], select_random[63:32]
    logic [0:0]        s_axis_tuser = '0;   // cmd[0]
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [W_OUT-1:0]  m_axis_tdata;        // species_a[0], species_b[1], species_c[2],
                                            // reaction_taken[4:3], event_time[52:5], zero
    logic [2:0]        m_axis_tuser;        // run_status[2:0]
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [W_ADDR-1:0] paddr = '0;
    logic [W_APB-1:0]  pwdata = '0;
    logic [W_APB-1:0]  prdata;
    logic              pready;

    int                mismatches;
    int                pending;
    int                live_results;
    logic              run_closed;

    int                burst_left = 0;
    int                idle_cycles = 0;
    logic [15:0]       ready_pattern = '1;
    logic [3:0]        ready_slot = '0;
    int                pattern_hold = 0;

    always #5 i_clk = ~i_clk;

    three_state_gillespie_step_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    gillespie_step_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (s_axis_tvalid),
        .i_in_ready     (s_axis_tready),
        .i_in_data      (s_axis_tdata),
        .i_in_cmd       (s_axis_tuser),
        .i_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .i_out_data     (m_axis_tdata),
        .i_out_status   (m_axis_tuser),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_mismatches   (mismatches),
        .o_pending      (pending),
        .o_live_results (live_results),
        .o_run_closed   (run_closed)
    );

    // receiver stalls follow a repeating 16-bit ready pattern that is redrawn now and then
    always @(posedge i_clk) begin
        if (pattern_hold == 0) begin
            pattern_hold <= $urandom_range(32, 400);
            case ($urandom_range(0, 3))
                0: ready_pattern <= '1;
                1: ready_pattern <= 16'($urandom) | 16'h0001;
                2: ready_pattern <= 16'($urandom | $urandom);
                default: ready_pattern <= 16'($urandom & $urandom) | 16'h0001;
            endcase
        end else begin
            pattern_hold <= pattern_hold - 1;
        end
        m_axis_tready <= ready_pattern[ready_slot];
        ready_slot <= ready_slot + 4'd1;
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one input transfer, then the sender may pause between bursts
    task automatic push_item(input logic cmd, input logic [31:0] wait_draw,
                             input logic [31:0] select_draw);
        int gap_cycles;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {select_draw, wait_draw};
        do @(posedge i_clk); while (!s_axis_tready);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            case ($urandom_range(0, 19))
                0: gap_cycles = $urandom_range(41, 150);
                1, 2, 3, 4, 5: gap_cycles = $urandom_range(5, 40);
                default: gap_cycles = $urandom_range(1, 4);
            endcase
            s_axis_tvalid <= 1'b0;
            repeat (gap_cycles) @(posedge i_clk);
        end
    endtask

    // setup phase, then access phase, then the bus is released before the task returns
    task automatic write_reg(input logic [2:0] index, input logic [W_APB-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 3'b000};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_config(input logic [31:0] k1, input logic [31:0] k2,
                               input logic [31:0] k3, input logic [31:0] k4,
                               input logic [47:0] stop_at);
        write_reg(REG_RATE_A_TO_B, {32'd0, k1});
        write_reg(REG_RATE_B_TO_A, {32'd0, k2});
        write_reg(REG_RATE_B_TO_C, {32'd0, k3});
        write_reg(REG_RATE_C_TO_A, {32'd0, k4});
        write_reg(REG_END_TIME, {16'd0, stop_at});
    endtask

    // stop sending and wait until every expected result is back
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_wait();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return $urandom_range(1, 255);
            2: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_select();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_rate();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            8, 9: return $urandom;
            default: return $urandom_range(32'h0000_4000, 32'h0004_0000);
        endcase
    endfunction

    function automatic logic [47:0] pick_end();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: return 48'd0;
            1: return '1;
            2, 3: return r[47:0];
            default: return {$urandom_range(1, 40), 16'd0};
        endcase
    endfunction

    initial begin
        int    phase;
        int    target;
        logic  restart;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default rates: extremes of the draws, restart with all ones
        push_item(1'b0, 32'd0, 32'd0);
        push_item(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_item(1'b0, 32'd1, 32'h8000_0000);
        push_item(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_item(1'b0, 32'h8000_0000, 32'd0);
        settle();

        // zero rate out of A halts the run, later advances are ignored
        write_reg(REG_RATE_A_TO_B, 64'd0);
        push_item(1'b1, 32'd0, 32'd0);
        push_item(1'b0, $urandom, $urandom);
        push_item(1'b0, $urandom, $urandom);
        settle();

        // all rates and the stop time at their maximum
        load_config('1, '1, '1, '1, '1);
        push_item(1'b1, $urandom, $urandom);
        push_item(1'b0, 32'hFFFF_FFFF, 32'd0);
        push_item(1'b0, 32'd0, 32'hFFFF_FFFF);
        push_item(1'b0, 32'h0000_0001, 32'h8000_0000);
        settle();

        // one rate out of B at zero forces the choice each way
        load_config('1, 32'd0, 32'd1, '1, '1);
        push_item(1'b1, $urandom, $urandom);
        push_item(1'b0, $urandom, $urandom);
        push_item(1'b0, $urandom, 32'd0);
        settle();
        write_reg(REG_RATE_B_TO_A, 64'd1);
        write_reg(REG_RATE_B_TO_C, 64'd0);
        push_item(1'b0, $urandom, $urandom);
        push_item(1'b0, $urandom, 32'hFFFF_FFFF);
        settle();
        write_reg(REG_RATE_B_TO_A, 64'd0);
        push_item(1'b0, $urandom, $urandom);
        push_item(1'b0, $urandom, $urandom);
        settle();

        // stop time moved below the running clock, then a stop time of zero
        load_config(RATE_RESET, RATE_RESET, RATE_RESET, RATE_RESET, END_RESET);
        push_item(1'b1, $urandom, $urandom);
        push_item(1'b0, 32'd1, $urandom);
        push_item(1'b0, 32'd1, $urandom);
        settle();
        write_reg(REG_END_TIME, 64'h0000_0000_0001_0000);
        push_item(1'b0, $urandom, $urandom);
        settle();
        write_reg(REG_END_TIME, 64'd0);
        push_item(1'b1, $urandom, $urandom);
        push_item(1'b0, $urandom, $urandom);
        settle();

        // random runs over a handful of settings
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            load_config(pick_rate(), pick_rate(), pick_rate(), pick_rate(), pick_end());
            push_item(1'b1, $urandom, $urandom);
            target = live_results + LIVE_PER_PHASE;
            while (live_results < target) begin
                if (run_closed) restart = ($urandom_range(0, 3) != 0);
                else restart = ($urandom_range(0, 49) == 0);
                push_item(restart, pick_wait(), pick_select());
            end
            settle();
        end

        settle();
        repeat (100) @(posedge i_clk);
        if (mismatches == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== three_state_gillespie_step_core.f =====
design/tsgs_pkg.sv
design/tsgs_div.sv
design/three_state_gillespie_step_core.sv
sim/gillespie_step_checker.sv
sim/three_state_gillespie_step_core_tb.sv
